// File: src/complex_number_alu_assert.svh
// Assertion macros shared by the complex number unit.
`ifndef COMPLEX_NUMBER_ALU_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CNA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cna_pkg.sv
// Shared types, constants and helper functions of the complex number unit.
`timescale 1ns / 1ps
package cna_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_BITS     = 30;
    localparam int ANG_W        = 35;
    localparam int ROUND_SH     = ANG_BITS - FRAC_BITS;

    localparam int SQRT_LAT   = 32;
    localparam int DIV_QBITS  = 33;
    localparam int DIV_LAT    = DIV_QBITS + 1;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;

    localparam int ST_MUL     = 2;
    localparam int ST_MOD     = 3 + SQRT_LAT;
    localparam int ST_DIV     = 3 + DIV_LAT;
    localparam int ST_ARG     = CORDIC_LAT + 1;
    localparam int ST_SQRT    = ST_MOD + SQRT_LAT + 1;
    localparam int PIPE_DEPTH = ST_SQRT;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [64:0] DIV_CAP = 65'h1_0000_0000;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_MUL   = 4'd2,
        MODE_DIV   = 4'd3,
        MODE_CONJ  = 4'd4,
        MODE_RECIP = 4'd5,
        MODE_MOD   = 4'd6,
        MODE_ARG   = 4'd7,
        MODE_SQRT  = 4'd8
    } mode_t;

    // Returns {saturated, value} for a sign and a magnitude.
    function automatic logic [DATA_W:0] pack_mag(input logic neg, input logic [64:0] mag);
        logic            sat;
        logic [DATA_W-1:0] val;
        if (!neg) begin
            sat = mag > 65'h0_7FFF_FFFF;
            val = sat ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
        end else begin
            sat = mag > 65'h0_8000_0000;
            val = sat ? 32'h8000_0000 : (~mag[DATA_W-1:0] + 32'd1);
        end
        return {sat, val};
    endfunction

    function automatic logic [DATA_W:0] pack_sgn(input logic signed [64:0] v);
        logic [64:0] mag;
        mag = v[64] ? 65'(-v) : 65'(v);
        return pack_mag(v[64], mag);
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [DATA_W-1:0] x,
                                                input logic signed [DATA_W-1:0] y);
        logic signed [63:0] xe;
        logic signed [63:0] ye;
        xe = 64'(x);
        ye = 64'(y);
        return xe * ye;
    endfunction

    function automatic logic [ANG_BITS-1:0] atan_q30(input logic [4:0] idx);
        logic [ANG_BITS-1:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/cna_req_if.sv
// Request channel of the complex number unit.
`timescale 1ns / 1ps
interface cna_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [3:0]                           mode;
    logic signed [cna_pkg::DATA_W-1:0]    a_re;
    logic signed [cna_pkg::DATA_W-1:0]    a_im;
    logic signed [cna_pkg::DATA_W-1:0]    b_re;
    logic signed [cna_pkg::DATA_W-1:0]    b_im;

    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: src/cna_rsp_if.sv
// Result channel of the complex number unit.
`timescale 1ns / 1ps
interface cna_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cna_pkg::DATA_W-1:0]    res_re;
    logic signed [cna_pkg::DATA_W-1:0]    res_im;
    logic                                 div_by_zero;
    logic                                 saturated;

    modport source (output valid, res_re, res_im, div_by_zero, saturated, input ready);
    modport sink   (input valid, res_re, res_im, div_by_zero, saturated, output ready);
endinterface

// File: src/cna_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module cna_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [63:0]                 n,
    output logic [cna_pkg::DATA_W-1:0]  root
);
    import cna_pkg::*;

    logic [63:0] rem_reg [SQRT_LAT];
    logic [63:0] acc_reg [SQRT_LAT];

    for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
        logic [63:0] rem_in;
        logic [63:0] acc_in;
        logic [63:0] bitv;
        logic [63:0] trial;

        if (i == 0) begin : g_first
            assign rem_in = n;
            assign acc_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign acc_in = acc_reg[i-1];
        end

        assign bitv  = 64'd1 << (62 - 2 * i);
        assign trial = acc_in + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[i] <= rem_in - trial;
                    acc_reg[i] <= (acc_in >> 1) + bitv;
                end
                else
                begin
                    rem_reg[i] <= rem_in;
                    acc_reg[i] <= acc_in >> 1;
                end
            end
        end
    end

    assign root = acc_reg[SQRT_LAT-1][DATA_W-1:0];

endmodule

// File: src/cna_divider.sv
// Pipelined restoring divider for the fixed-point quotient.
`timescale 1ns / 1ps
module cna_divider (
    input  logic                            clk,
    input  logic                            en,
    input  logic [63:0]                     mag,
    input  logic [63:0]                     den,
    output logic [cna_pkg::DIV_QBITS-1:0]   quo,
    output logic                            ovf
);
    import cna_pkg::*;

    localparam int REM_W  = 64 + FRAC_BITS;
    localparam int SH_W   = 64 + DIV_QBITS + 1;
    localparam int OVF_SH = DIV_QBITS - FRAC_BITS;
    localparam int OVF_W  = 64 + OVF_SH;

    logic [REM_W-1:0]     rem_reg [DIV_QBITS+1];
    logic [63:0]          den_reg [DIV_QBITS+1];
    logic [DIV_QBITS-1:0] q_reg   [DIV_QBITS+1];
    logic                 ovf_reg [DIV_QBITS+1];

    // A quotient of 2^DIV_QBITS or more is flagged here and saturates later.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {mag, {FRAC_BITS{1'b0}}};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= OVF_W'(mag) >= (OVF_W'(den) << OVF_SH);
        end
    end

    for (genvar j = 0; j < DIV_QBITS; j++) begin : g_stage
        localparam int K = DIV_QBITS - 1 - j;
        logic [SH_W-1:0] dsh;
        logic            ge;

        assign dsh = SH_W'(den_reg[j]) << K;
        assign ge  = SH_W'(rem_reg[j]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? (rem_reg[j] - dsh[REM_W-1:0]) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (ge ? (DIV_QBITS'(1) << K) : '0);
                den_reg[j+1] <= den_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo = q_reg[DIV_QBITS];
    assign ovf = ovf_reg[DIV_QBITS];

endmodule

// File: src/cna_cordic.sv
// Pipelined CORDIC vectoring unit for the argument of a complex value.
`timescale 1ns / 1ps
module cna_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [cna_pkg::DATA_W-1:0]   a_re,
    input  logic signed [cna_pkg::DATA_W-1:0]   a_im,
    output logic [cna_pkg::DATA_W-1:0]          angle
);
    import cna_pkg::*;

    logic signed [63:0]      x_reg    [CORDIC_STEPS+1];
    logic signed [63:0]      y_reg    [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] z_reg    [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] corr_reg [CORDIC_STEPS+1];
    logic                    hold_reg [CORDIC_STEPS+1];
    logic [DATA_W-1:0]       angle_reg;

    logic signed [63:0]      x_next;
    logic signed [63:0]      y_next;
    logic signed [ANG_W-1:0] z_next;
    logic signed [ANG_W-1:0] corr_next;
    logic                    hold_next;

    // Points on the imaginary axis take their angle directly; the left half
    // plane is turned by pi before the iterations.
    always_comb
    begin
        hold_next = (a_re == '0);
        z_next    = '0;
        corr_next = '0;
        if (a_re < 0)
        begin
            x_next    = (-64'(a_re)) <<< ANG_BITS;
            y_next    = (-64'(a_im)) <<< ANG_BITS;
            corr_next = (a_im >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            x_next = 64'(a_re) <<< ANG_BITS;
            y_next = 64'(a_im) <<< ANG_BITS;
        end
        if (hold_next && a_im > 0)
        begin
            z_next = HALF_PI_Q30;
        end
        else if (hold_next && a_im < 0)
        begin
            z_next = -HALF_PI_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            corr_reg[0] <= corr_next;
            hold_reg[0] <= hold_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [63:0]      dx;
        logic signed [63:0]      dy;
        logic signed [ANG_W-1:0] at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = ANG_W'(atan_q30(5'(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                corr_reg[i+1] <= corr_reg[i];
                hold_reg[i+1] <= hold_reg[i];
                if (hold_reg[i])
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
                else if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
            end
        end
    end

    logic signed [ANG_W-1:0] z_tot;
    logic signed [ANG_W-1:0] z_rnd;

    assign z_tot = z_reg[CORDIC_STEPS] + corr_reg[CORDIC_STEPS];
    assign z_rnd = (z_tot + (ANG_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= z_rnd[DATA_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

// File: src/complex_number_alu.sv
// Top level of the pipelined complex number unit.
`timescale 1ns / 1ps
`include "complex_number_alu_assert.svh"
// The unit accepts one request in every cycle unless stalled, and returns the results
// in request order, whatever the operation. The latency is set by square root,
// whose modulus and the two half-angle roots pass through two 32-stage square
// root pipelines in series; divide runs in a 34-stage divider and argument in a
// CORDIC pipeline alongside. A two-entry output buffer lets the pipeline keep
// accepting requests while a finished result waits, and the request side stalls
// only once both entries are full.
module complex_number_alu (
    input  logic      clk,
    input  logic      rst_n,
    cna_req_if.sink   req,
    cna_rsp_if.source rsp
);
    import cna_pkg::*;

    typedef struct packed {
        logic [3:0]        mode;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              dz;
        logic              sat;
        logic              neg_re;
        logic              neg_im;
        logic [DATA_W-1:0] ar;
        logic              aineg;
    } side_t;

    logic                  en;
    logic                  push;
    logic                  pop;
    logic [PIPE_DEPTH:1]   vld_reg;
    side_t                 side_reg [1:PIPE_DEPTH];
    side_t                 o_reg;
    side_t                 s_reg;
    logic                  o_v_reg;
    logic                  s_v_reg;

    logic signed [DATA_W-1:0] op_ar;
    logic signed [DATA_W-1:0] op_ai;
    logic signed [DATA_W-1:0] op_br;
    logic signed [DATA_W-1:0] op_bi;
    logic [DATA_W:0]          pk_re;
    logic [DATA_W:0]          pk_im;
    side_t                    side1;

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    assign en        = !s_v_reg;
    assign req.ready = en;
    assign push      = en && vld_reg[PIPE_DEPTH];
    assign pop       = o_v_reg && rsp.ready;

    // Request decode and the operations that finish in the first stage.
    always_comb
    begin
        op_ar       = req.a_re;
        op_ai       = req.a_im;
        op_br       = req.b_re;
        op_bi       = req.b_im;
        pk_re       = '0;
        pk_im       = '0;
        side1       = '0;
        side1.mode  = req.mode;
        side1.ar    = req.a_re;
        side1.aineg = req.a_im[DATA_W-1];
        unique case (req.mode) inside
            MODE_ADD:
            begin
                pk_re = pack_sgn(65'(req.a_re) + 65'(req.b_re));
                pk_im = pack_sgn(65'(req.a_im) + 65'(req.b_im));
            end
            MODE_SUB:
            begin
                pk_re = pack_sgn(65'(req.a_re) - 65'(req.b_re));
                pk_im = pack_sgn(65'(req.a_im) - 65'(req.b_im));
            end
            MODE_CONJ:
            begin
                pk_re = pack_sgn(65'(req.a_re));
                pk_im = pack_sgn(-65'(req.a_im));
            end
            MODE_DIV:
            begin
                side1.dz = (req.b_re == '0) && (req.b_im == '0);
            end
            MODE_RECIP:
            begin
                op_ar    = ONE_Q;
                op_ai    = '0;
                op_br    = req.a_re;
                op_bi    = req.a_im;
                side1.dz = (req.a_re == '0) && (req.a_im == '0);
            end
            MODE_MOD, MODE_SQRT:
            begin
                op_br = req.a_re;
                op_bi = req.a_im;
            end
            default:
            begin
            end
        endcase
        side1.re  = pk_re[DATA_W-1:0];
        side1.im  = pk_im[DATA_W-1:0];
        side1.sat = pk_re[DATA_W] | pk_im[DATA_W];
    end

    // Stage 1: partial products.
    logic signed [63:0] p_rr_reg;
    logic signed [63:0] p_ii_reg;
    logic signed [63:0] p_ri_reg;
    logic signed [63:0] p_ir_reg;
    logic [63:0]        s_rr_reg;
    logic [63:0]        s_ii_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg    <= smul(op_ar, op_br);
            p_ii_reg    <= smul(op_ai, op_bi);
            p_ri_reg    <= smul(op_ar, op_bi);
            p_ir_reg    <= smul(op_ai, op_br);
            s_rr_reg    <= smul(op_br, op_br);
            s_ii_reg    <= smul(op_bi, op_bi);
            side_reg[1] <= side1;
        end
    end

    // Stage 2: sums of products.
    logic signed [64:0] vm_re;
    logic signed [64:0] vm_im;
    logic signed [64:0] vd_re;
    logic signed [64:0] vd_im;
    logic [64:0]        mm_re;
    logic [64:0]        mm_im;
    logic [DATA_W:0]    mul_pk_re;
    logic [DATA_W:0]    mul_pk_im;
    logic [63:0]        dn_re_reg;
    logic [63:0]        dn_im_reg;
    logic [63:0]        den_reg;

    assign vm_re     = 65'(p_rr_reg) - 65'(p_ii_reg);
    assign vm_im     = 65'(p_ri_reg) + 65'(p_ir_reg);
    assign vd_re     = 65'(p_rr_reg) + 65'(p_ii_reg);
    assign vd_im     = 65'(p_ir_reg) - 65'(p_ri_reg);
    assign mm_re     = vm_re[64] ? 65'(-vm_re) : 65'(vm_re);
    assign mm_im     = vm_im[64] ? 65'(-vm_im) : 65'(vm_im);
    assign mul_pk_re = pack_mag(vm_re[64], mm_re >> FRAC_BITS);
    assign mul_pk_im = pack_mag(vm_im[64], mm_im >> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_re_reg <= vd_re[64] ? 64'(-vd_re) : vd_re[63:0];
            dn_im_reg <= vd_im[64] ? 64'(-vd_im) : vd_im[63:0];
            den_reg   <= s_rr_reg + s_ii_reg;
        end
    end

    // Long-latency units.
    logic [DIV_QBITS-1:0] q_re;
    logic [DIV_QBITS-1:0] q_im;
    logic                 q_ovf_re;
    logic                 q_ovf_im;
    logic [DATA_W-1:0]    m_root;
    logic [DATA_W-1:0]    r_re;
    logic [DATA_W-1:0]    r_im;
    logic [DATA_W-1:0]    arg_val;
    logic [63:0]          pr_sh_reg;
    logic [63:0]          qi_sh_reg;

    cna_divider u_div_re (
        .clk (clk),
        .en  (en),
        .mag (dn_re_reg),
        .den (den_reg),
        .quo (q_re),
        .ovf (q_ovf_re)
    );

    cna_divider u_div_im (
        .clk (clk),
        .en  (en),
        .mag (dn_im_reg),
        .den (den_reg),
        .quo (q_im),
        .ovf (q_ovf_im)
    );

    cna_sqrt u_sqrt_mod (
        .clk  (clk),
        .en   (en),
        .n    (den_reg),
        .root (m_root)
    );

    logic signed [33:0] mx;
    logic signed [33:0] ax;
    logic signed [33:0] prs;
    logic signed [33:0] qis;

    assign mx  = signed'({2'b00, m_root});
    assign ax  = 34'(signed'(side_reg[ST_MOD-1].ar));
    assign prs = mx + ax;
    assign qis = mx - ax;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_sh_reg <= 64'(prs[32:0]) << (FRAC_BITS - 1);
            qi_sh_reg <= 64'(qis[32:0]) << (FRAC_BITS - 1);
        end
    end

    cna_sqrt u_sqrt_re (
        .clk  (clk),
        .en   (en),
        .n    (pr_sh_reg),
        .root (r_re)
    );

    cna_sqrt u_sqrt_im (
        .clk  (clk),
        .en   (en),
        .n    (qi_sh_reg),
        .root (r_im)
    );

    cna_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .a_re  (req.a_re),
        .a_im  (req.a_im),
        .angle (arg_val)
    );

    logic [DATA_W:0] div_pk_re;
    logic [DATA_W:0] div_pk_im;
    logic [DATA_W:0] mod_pk;
    logic [DATA_W:0] sqrt_pk_re;
    logic [DATA_W:0] sqrt_pk_im;

    assign div_pk_re  = pack_mag(side_reg[ST_DIV-1].neg_re, q_ovf_re ? DIV_CAP : 65'(q_re));
    assign div_pk_im  = pack_mag(side_reg[ST_DIV-1].neg_im, q_ovf_im ? DIV_CAP : 65'(q_im));
    assign mod_pk     = pack_mag(1'b0, 65'(m_root));
    assign sqrt_pk_re = pack_mag(1'b0, 65'(r_re));
    assign sqrt_pk_im = pack_mag(side_reg[ST_SQRT-1].aineg, 65'(r_im));

    // Result line: each operation drops its value in where its unit finishes.
    for (genvar k = 2; k <= PIPE_DEPTH; k++) begin : g_side
        side_t nxt;

        always_comb
        begin
            nxt = side_reg[k-1];
            if (k == ST_MUL)
            begin
                nxt.neg_re = vd_re[64];
                nxt.neg_im = vd_im[64];
                if (nxt.mode == MODE_MUL)
                begin
                    nxt.re  = mul_pk_re[DATA_W-1:0];
                    nxt.im  = mul_pk_im[DATA_W-1:0];
                    nxt.sat = mul_pk_re[DATA_W] | mul_pk_im[DATA_W];
                end
            end
            if (k == ST_ARG && nxt.mode == MODE_ARG)
            begin
                nxt.re = arg_val;
                nxt.im = '0;
            end
            if (k == ST_MOD && nxt.mode == MODE_MOD)
            begin
                nxt.re  = mod_pk[DATA_W-1:0];
                nxt.sat = mod_pk[DATA_W];
            end
            if (k == ST_DIV && (nxt.mode == MODE_DIV || nxt.mode == MODE_RECIP) && !nxt.dz)
            begin
                nxt.re  = div_pk_re[DATA_W-1:0];
                nxt.im  = div_pk_im[DATA_W-1:0];
                nxt.sat = div_pk_re[DATA_W] | div_pk_im[DATA_W];
            end
            if (k == ST_SQRT && nxt.mode == MODE_SQRT)
            begin
                nxt.re  = sqrt_pk_re[DATA_W-1:0];
                nxt.im  = sqrt_pk_im[DATA_W-1:0];
                nxt.sat = sqrt_pk_re[DATA_W] | sqrt_pk_im[DATA_W];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:1], req.valid};
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (s_v_reg)
            begin
                s_v_reg <= 1'b0;
            end
            else
            begin
                o_v_reg <= push;
            end
        end
        else if (push && o_v_reg)
        begin
            s_v_reg <= 1'b1;
        end
        else if (push)
        begin
            o_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && s_v_reg)
        begin
            o_reg <= s_reg;
        end
        else if (push && (pop || !o_v_reg))
        begin
            o_reg <= side_reg[PIPE_DEPTH];
        end
        if (push && o_v_reg && !pop)
        begin
            s_reg <= side_reg[PIPE_DEPTH];
        end
    end

    assign rsp.valid       = o_v_reg;
    assign rsp.res_re      = o_reg.re;
    assign rsp.res_im      = o_reg.im;
    assign rsp.div_by_zero = o_reg.dz;
    assign rsp.saturated   = o_reg.sat;

    `CNA_ASSERT_IMP(a_dz_mode, o_v_reg && o_reg.dz, (o_reg.mode == MODE_DIV) || (o_reg.mode == MODE_RECIP), "zero divisor flag on a mode other than divide or reciprocal")
    `CNA_ASSERT_IMP(a_dz_zero, o_v_reg && o_reg.dz, (o_reg.re == '0) && (o_reg.im == '0) && !o_reg.sat, "zero divisor result is not zero")
    `CNA_ASSERT_IMP(a_scalar_im, o_v_reg && ((o_reg.mode == MODE_MOD) || (o_reg.mode == MODE_ARG)), o_reg.im == '0, "modulus or argument with a nonzero imaginary part")
    `CNA_ASSERT_IMP(a_skid_order, s_v_reg, o_v_reg, "skid entry holds a result while the output is empty")
    `CNA_ASSERT_NXT(a_skid_fill, !s_v_reg && o_v_reg && !rsp.ready && vld_reg[PIPE_DEPTH], s_v_reg, "stalled result was not caught by the skid entry")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the complex number unit: directed and random requests.
`timescale 1ns / 1ps
module tb;
    import cna_pkg::*;

    localparam int NUM_RANDOM = 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;

    typedef logic signed [65:0] wide_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } cplx_res_t;

    typedef struct {
        logic [3:0]  mode;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        bit          fixed;
        cplx_res_t   want;
    } stim_row_t;

    typedef struct {
        bit        fixed;
        cplx_res_t want;
    } pending_t;

    localparam logic [29:0] ARCTAN_Q30 [16] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687, 30'd33543516, 30'd16775851, 30'd8388437,
        30'd4194283, 30'd2097149, 30'd1048576, 30'd524288,
        30'd262144, 30'd131072, 30'd65536, 30'd32768
    };
    localparam logic signed [65:0] PI_ANGLE = 66'sd3373259426;
    localparam logic signed [65:0] HALF_PI_ANGLE = 66'sd1686629713;

    logic clk;
    logic rst_n;
    cna_req_if req ();
    cna_rsp_if rsp ();

    complex_number_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    cplx_res_t expected_q[$];
    pending_t  request_tags_q[$];
    stim_row_t rows[$];
    int        accepted_cnt;
    int        error_cnt;
    int        cycle_cnt;
    bit        calm;

    initial begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    function automatic logic [31:0] clip_mag(input bit neg, input logic [65:0] mag,
                                             inout bit sat);
        if (!neg) begin
            if (mag > 66'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 66'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -mag[31:0];
    endfunction

    function automatic logic [31:0] clip_signed(input wide_t v, inout bit sat);
        logic [65:0] mag;
        mag = (v < 0) ? -v : v;
        return clip_mag(v < 0, mag, sat);
    endfunction

    function automatic logic [65:0] frac_quotient(input logic [65:0] mag,
                                                  input logic [65:0] d);
        logic [97:0] q;
        q = {32'd0, mag} << 16;
        q = q / {32'd0, d};
        if (q >= (98'd1 << 48))
            return 66'h1_0000_0000;
        return q[65:0];
    endfunction

    function automatic logic [65:0] int_sqrt(input logic [65:0] n);
        logic [65:0] res;
        logic [65:0] b;
        res = '0;
        b = 66'd1 << 64;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic cplx_res_t complex_divide(input wide_t ar, input wide_t ai,
                                                 input wide_t br, input wide_t bi);
        cplx_res_t r;
        wide_t     d;
        wide_t     nr;
        wide_t     ni;
        bit        sat;
        r = '0;
        sat = 1'b0;
        d = br * br + bi * bi;
        if (d == 0) begin
            r.dz = 1'b1;
            return r;
        end
        nr = ar * br + ai * bi;
        ni = ai * br - ar * bi;
        r.re = clip_mag(nr < 0, frac_quotient((nr < 0) ? -nr : nr, d), sat);
        r.im = clip_mag(ni < 0, frac_quotient((ni < 0) ? -ni : ni, d), sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic cplx_res_t predict_result(input logic [3:0] mode,
                                                 input logic signed [31:0] a_re,
                                                 input logic signed [31:0] a_im,
                                                 input logic signed [31:0] b_re,
                                                 input logic signed [31:0] b_im);
        cplx_res_t   r;
        wide_t       ar;
        wide_t       ai;
        wide_t       br;
        wide_t       bi;
        wide_t       s;
        wide_t       x;
        wide_t       y;
        wide_t       z;
        wide_t       dx;
        wide_t       dy;
        wide_t       turn;
        logic [65:0] m;
        bit          sat;
        r = '0;
        sat = 1'b0;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        case (mode)
            MODE_ADD: begin
                r.re = clip_signed(ar + br, sat);
                r.im = clip_signed(ai + bi, sat);
            end
            MODE_SUB: begin
                r.re = clip_signed(ar - br, sat);
                r.im = clip_signed(ai - bi, sat);
            end
            MODE_MUL: begin
                s = ar * br - ai * bi;
                m = (s < 0) ? -s : s;
                r.re = clip_mag(s < 0, m >> FRAC_BITS, sat);
                s = ar * bi + ai * br;
                m = (s < 0) ? -s : s;
                r.im = clip_mag(s < 0, m >> FRAC_BITS, sat);
            end
            MODE_DIV:   return complex_divide(ar, ai, br, bi);
            MODE_RECIP: return complex_divide(66'sd65536, 66'sd0, ar, ai);
            MODE_CONJ: begin
                r.re = clip_signed(ar, sat);
                r.im = clip_signed(-ai, sat);
            end
            MODE_MOD: begin
                r.re = clip_mag(1'b0, int_sqrt(ar * ar + ai * ai), sat);
            end
            MODE_ARG: begin
                z = '0;
                if (ar == 0 && ai == 0) begin
                    z = '0;
                end else if (ar == 0) begin
                    z = (ai > 0) ? HALF_PI_ANGLE : -HALF_PI_ANGLE;
                end else begin
                    turn = '0;
                    if (ar < 0) begin
                        x = -ar;
                        y = -ai;
                        turn = (ai >= 0) ? PI_ANGLE : -PI_ANGLE;
                    end else begin
                        x = ar;
                        y = ai;
                    end
                    x = x <<< 30;
                    y = y <<< 30;
                    for (int i = 0; i < CORDIC_STEPS; i++) begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (y >= 0) begin
                            x = x + dx;
                            y = y - dy;
                            z = z + wide_t'(ARCTAN_Q30[i]);
                        end else begin
                            x = x - dx;
                            y = y + dy;
                            z = z - wide_t'(ARCTAN_Q30[i]);
                        end
                    end
                    z = z + turn;
                end
                z = (z + (66'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
                r.re = clip_signed(z, sat);
            end
            MODE_SQRT: begin
                m = int_sqrt(ar * ar + ai * ai);
                s = wide_t'(m) + ar;
                r.re = clip_mag(1'b0, int_sqrt(s << (FRAC_BITS - 1)), sat);
                s = wide_t'(m) - ar;
                r.im = clip_mag(ai < 0, int_sqrt(s << (FRAC_BITS - 1)), sat);
            end
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            8:       return '0;
            default: return 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic stim_row_t make_row(input logic [3:0] mode,
                                           input logic [31:0] ar, input logic [31:0] ai,
                                           input logic [31:0] br, input logic [31:0] bi,
                                           input bit fixed, input cplx_res_t want);
        stim_row_t row;
        row.mode = mode;
        row.ar = ar;
        row.ai = ai;
        row.br = br;
        row.bi = bi;
        row.fixed = fixed;
        row.want = want;
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_cnt++;
        end
    endtask

    always @(posedge clk) begin
        cplx_res_t want;
        pending_t  tag;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (rst_n) begin
            if (req.valid && req.ready) begin
                tag = request_tags_q.pop_front();
                if (tag.fixed)
                    expected_q.push_back(tag.want);
                else
                    expected_q.push_back(predict_result(req.mode, req.a_re, req.a_im,
                                                        req.b_re, req.b_im));
                accepted_cnt++;
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %h",
                             $time, rsp.res_re, rsp.res_im);
                    error_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("res_re", want.re, rsp.res_re);
                    check_field("res_im", want.im, rsp.res_im);
                    check_field("div_by_zero", 32'(want.dz), 32'(rsp.div_by_zero));
                    check_field("saturated", 32'(want.sat), 32'(rsp.saturated));
                end
            end
        end
    end

    always @(negedge clk) begin
        rsp.ready = calm || ($urandom_range(0, 99) >= 15);
    end

    task automatic send_request(input stim_row_t row);
        pending_t tag;
        int       target;
        while (!calm && $urandom_range(0, 99) < 15) begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        tag.fixed = row.fixed;
        tag.want = row.want;
        request_tags_q.push_back(tag);
        target = accepted_cnt + 1;
        req.mode = row.mode;
        req.a_re = row.ar;
        req.a_im = row.ai;
        req.b_re = row.br;
        req.b_im = row.bi;
        req.valid = 1'b1;
        do
            @(negedge clk);
        while (accepted_cnt != target);
    endtask

    initial begin
        stim_row_t row;
        logic [3:0] mode;
        cplx_res_t none;
        none = '0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.mode = '0;
        req.a_re = '0;
        req.a_im = '0;
        req.b_re = '0;
        req.b_im = '0;
        rsp.ready = 1'b0;
        calm = 1'b0;
        accepted_cnt = 0;
        error_cnt = 0;
        cycle_cnt = 0;

        rows.push_back(make_row(MODE_ADD, 0, 0, 0, 0, 1, none));
        rows.push_back(make_row(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1}));
        rows.push_back(make_row(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 1, '{32'h8000_0000, 32'h8000_0000, 0, 1}));
        rows.push_back(make_row(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 0, none));
        rows.push_back(make_row(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 0, none));
        rows.push_back(make_row(MODE_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0, 1,
                                '{32'd0, 32'd0, 1, 0}));
        rows.push_back(make_row(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                32'h0000_0000, 0, none));
        rows.push_back(make_row(MODE_DIV, 32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000,
                                32'h0002_0000, 0, none));
        rows.push_back(make_row(MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 0, 0, 1,
                                '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1}));
        rows.push_back(make_row(MODE_RECIP, 0, 0, 0, 0, 1, '{32'd0, 32'd0, 1, 0}));
        rows.push_back(make_row(MODE_RECIP, 32'h0001_0000, 0, 0, 0, 1,
                                '{32'h0001_0000, 32'd0, 0, 0}));
        rows.push_back(make_row(MODE_RECIP, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, none));
        rows.push_back(make_row(MODE_MOD, 32'h0003_0000, 32'h0004_0000, 0, 0, 1,
                                '{32'h0005_0000, 32'd0, 0, 0}));
        rows.push_back(make_row(MODE_MOD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, none));
        rows.push_back(make_row(MODE_ARG, 0, 0, 0, 0, 1, none));
        rows.push_back(make_row(MODE_ARG, 0, 32'h0000_0005, 0, 0, 1,
                                '{32'sd102944, 32'd0, 0, 0}));
        rows.push_back(make_row(MODE_ARG, 0, 32'h8000_0000, 0, 0, 1,
                                '{-32'sd102944, 32'd0, 0, 0}));
        rows.push_back(make_row(MODE_ARG, 32'hFFFF_0000, 0, 0, 0, 0, none));
        rows.push_back(make_row(MODE_ARG, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, none));
        rows.push_back(make_row(MODE_ARG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, none));
        rows.push_back(make_row(MODE_SQRT, 32'hFFFC_0000, 0, 0, 0, 1,
                                '{32'd0, 32'h0002_0000, 0, 0}));
        rows.push_back(make_row(MODE_SQRT, 0, 0, 0, 0, 1, none));
        rows.push_back(make_row(MODE_SQRT, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, none));
        rows.push_back(make_row(4'd9, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
                                32'h0F0F_0F0F, 1, none));
        rows.push_back(make_row(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1, none));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_request(rows[i]);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= 150 && n < 250);
            if ($urandom_range(0, 99) < 5)
                mode = 4'($urandom_range(9, 15));
            else
                mode = 4'($urandom_range(0, 8));
            row = make_row(mode, random_operand(), random_operand(), random_operand(),
                           random_operand(), 0, none);
            if (mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
                row.br = '0;
                row.bi = '0;
            end
            if (mode == MODE_RECIP && $urandom_range(0, 9) == 0) begin
                row.ar = '0;
                row.ai = '0;
            end
            send_request(row);
        end
        calm = 1'b0;
        req.valid = 1'b0;

        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/cna_pkg.sv
src/cna_req_if.sv
src/cna_rsp_if.sv
src/cna_sqrt.sv
src/cna_divider.sv
src/cna_cordic.sv
src/complex_number_alu.sv
tb/sv/tb.sv
